// ----- rtl/stt_pkg.sv -----
// stt_pkg: token kinds, byte codes, lexer modes and the token/bundle types
// shared by the tokenizer modules; no dependencies
package stt_pkg;

    localparam int MAX_TOKENS = 3;
    localparam int QDEPTH     = 4;

    // token kinds
    localparam logic [5:0] K_EOF = 6'd0, K_IDENT = 6'd1, K_INT = 6'd2, K_FLOAT = 6'd3;
    localparam logic [5:0] K_CHAR = 6'd4, K_STRING = 6'd5, K_UNKNOWN = 6'd6;
    localparam logic [5:0] K_LBRACE = 6'd7, K_RBRACE = 6'd8, K_LBRK = 6'd9, K_RBRK = 6'd10;
    localparam logic [5:0] K_LPAR = 6'd11, K_RPAR = 6'd12, K_SEMI = 6'd13, K_QUEST = 6'd14;
    localparam logic [5:0] K_TILDE = 6'd15, K_COMMA = 6'd16, K_NOT = 6'd17, K_NE = 6'd18;
    localparam logic [5:0] K_HASH = 6'd19, K_PASTE = 6'd20, K_COLON = 6'd21, K_SCOPE = 6'd22;
    localparam logic [5:0] K_DOT = 6'd23, K_ELLIP = 6'd24, K_DOTSTAR = 6'd25;
    localparam logic [5:0] K_PLUS = 6'd26, K_INC = 6'd27, K_ADDEQ = 6'd28;
    localparam logic [5:0] K_MINUS = 6'd29, K_DEC = 6'd30, K_SUBEQ = 6'd31;
    localparam logic [5:0] K_ARROW = 6'd32, K_ARROWSTAR = 6'd33;
    localparam logic [5:0] K_STAR = 6'd34, K_MULEQ = 6'd35, K_SLASH = 6'd36, K_DIVEQ = 6'd37;
    localparam logic [5:0] K_PCT = 6'd38, K_MODEQ = 6'd39, K_CARET = 6'd40, K_XOREQ = 6'd41;
    localparam logic [5:0] K_AMP = 6'd42, K_LAND = 6'd43, K_ANDEQ = 6'd44;
    localparam logic [5:0] K_BAR = 6'd45, K_LOR = 6'd46, K_OREQ = 6'd47;
    localparam logic [5:0] K_ASSIGN = 6'd48, K_EQ = 6'd49;
    localparam logic [5:0] K_LT = 6'd50, K_SHL = 6'd51, K_SHLEQ = 6'd52, K_LE = 6'd53;
    localparam logic [5:0] K_GT = 6'd54, K_SHR = 6'd55, K_SHREQ = 6'd56, K_GE = 6'd57;

    // byte codes
    localparam logic [7:0] C_TAB = 8'h09, C_LF = 8'h0a, C_VT = 8'h0b, C_FF = 8'h0c;
    localparam logic [7:0] C_CR = 8'h0d, C_SP = 8'h20, C_BANG = 8'h21, C_DQ = 8'h22;
    localparam logic [7:0] C_HASH = 8'h23, C_PCT = 8'h25, C_AMP = 8'h26, C_SQ = 8'h27;
    localparam logic [7:0] C_LPAR = 8'h28, C_RPAR = 8'h29, C_STAR = 8'h2a, C_PLUS = 8'h2b;
    localparam logic [7:0] C_COMMA = 8'h2c, C_MINUS = 8'h2d, C_DOT = 8'h2e, C_SLASH = 8'h2f;
    localparam logic [7:0] C_ZERO = 8'h30, C_NINE = 8'h39, C_COLON = 8'h3a, C_SEMI = 8'h3b;
    localparam logic [7:0] C_LT = 8'h3c, C_EQ = 8'h3d, C_GT = 8'h3e, C_QUEST = 8'h3f;
    localparam logic [7:0] C_UA = 8'h41, C_UZ = 8'h5a, C_LBRK = 8'h5b, C_BSL = 8'h5c;
    localparam logic [7:0] C_RBRK = 8'h5d, C_CARET = 8'h5e, C_USCORE = 8'h5f, C_LA = 8'h61;
    localparam logic [7:0] C_X = 8'h78, C_LZ = 8'h7a, C_LBRACE = 8'h7b, C_BAR = 8'h7c;
    localparam logic [7:0] C_RBRACE = 8'h7d, C_TILDE = 8'h7e;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMZ, M_NUM, M_LIT, M_LINE, M_BLOCK, M_PUNCT
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
    } t_token;

    typedef struct packed {
        t_token [MAX_TOKENS-1:0] tok;
        logic [1:0]              cnt;
    } t_bundle;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    // punctuator decision with one following byte known
    typedef struct packed {
        logic       more;
        logic       line;
        logic       block;
        logic       two;
        logic [5:0] kind;
    } t_dec;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {C_SP, C_TAB, C_FF, C_VT, C_CR, C_LF};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[C_ZERO:C_NINE]};
    endfunction

    function automatic logic is_head(input logic [7:0] c);
        return c inside {C_USCORE, [C_UA:C_UZ], [C_LA:C_LZ]};
    endfunction

    function automatic logic needs_look(input logic [7:0] c);
        return c inside {C_BANG, C_HASH, C_COLON, C_DOT, C_PLUS, C_MINUS, C_STAR, C_SLASH,
                         C_PCT, C_CARET, C_AMP, C_BAR, C_EQ, C_LT, C_GT};
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            C_LBRACE: k = K_LBRACE;
            C_RBRACE: k = K_RBRACE;
            C_LBRK:   k = K_LBRK;
            C_RBRK:   k = K_RBRK;
            C_LPAR:   k = K_LPAR;
            C_RPAR:   k = K_RPAR;
            C_SEMI:   k = K_SEMI;
            C_QUEST:  k = K_QUEST;
            C_TILDE:  k = K_TILDE;
            C_COMMA:  k = K_COMMA;
            default:  k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    // kind of a lone punctuator byte
    function automatic logic [5:0] punct_base(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            C_BANG:  k = K_NOT;
            C_HASH:  k = K_HASH;
            C_COLON: k = K_COLON;
            C_DOT:   k = K_DOT;
            C_PLUS:  k = K_PLUS;
            C_MINUS: k = K_MINUS;
            C_STAR:  k = K_STAR;
            C_SLASH: k = K_SLASH;
            C_PCT:   k = K_PCT;
            C_CARET: k = K_CARET;
            C_AMP:   k = K_AMP;
            C_BAR:   k = K_BAR;
            C_EQ:    k = K_ASSIGN;
            C_LT:    k = K_LT;
            C_GT:    k = K_GT;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic t_dec decide(input logic [7:0] s0, input logic [7:0] a);
        t_dec d;
        d      = '0;
        d.kind = punct_base(s0);
        case (s0)
            C_BANG:  if (a == C_EQ) begin d.kind = K_NE;    d.two = 1'b1; end
            C_STAR:  if (a == C_EQ) begin d.kind = K_MULEQ; d.two = 1'b1; end
            C_PCT:   if (a == C_EQ) begin d.kind = K_MODEQ; d.two = 1'b1; end
            C_CARET: if (a == C_EQ) begin d.kind = K_XOREQ; d.two = 1'b1; end
            C_EQ:    if (a == C_EQ) begin d.kind = K_EQ;    d.two = 1'b1; end
            C_HASH:  if (a == C_HASH) begin d.kind = K_PASTE; d.two = 1'b1; end
            C_COLON: if (a == C_COLON) begin d.kind = K_SCOPE; d.two = 1'b1; end
            C_PLUS: begin
                if (a == C_PLUS) begin d.kind = K_INC; d.two = 1'b1; end
                else if (a == C_EQ) begin d.kind = K_ADDEQ; d.two = 1'b1; end
            end
            C_AMP: begin
                if (a == C_AMP) begin d.kind = K_LAND; d.two = 1'b1; end
                else if (a == C_EQ) begin d.kind = K_ANDEQ; d.two = 1'b1; end
            end
            C_BAR: begin
                if (a == C_BAR) begin d.kind = K_LOR; d.two = 1'b1; end
                else if (a == C_EQ) begin d.kind = K_OREQ; d.two = 1'b1; end
            end
            C_DOT: begin
                if (a == C_DOT) d.more = 1'b1;
                else if (a == C_STAR) begin d.kind = K_DOTSTAR; d.two = 1'b1; end
            end
            C_MINUS: begin
                if (a == C_MINUS) begin d.kind = K_DEC; d.two = 1'b1; end
                else if (a == C_EQ) begin d.kind = K_SUBEQ; d.two = 1'b1; end
                else if (a == C_GT) d.more = 1'b1;
            end
            C_SLASH: begin
                if (a == C_SLASH) d.line = 1'b1;
                else if (a == C_STAR) d.block = 1'b1;
                else if (a == C_EQ) begin d.kind = K_DIVEQ; d.two = 1'b1; end
            end
            C_LT: begin
                if (a == C_LT) d.more = 1'b1;
                else if (a == C_EQ) begin d.kind = K_LE; d.two = 1'b1; end
            end
            C_GT: begin
                if (a == C_GT) d.more = 1'b1;
                else if (a == C_EQ) begin d.kind = K_GE; d.two = 1'b1; end
            end
            default: d.kind = K_UNKNOWN;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/stt_if.sv -----
// stt_in_if / stt_out_if: valid-ready channels for text bytes and tokens
// depends on nothing
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;
    modport source (output valid, ch, end_of_text, input ready);
    modport sink (input valid, ch, end_of_text, output ready);
endinterface

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        last_of_run;
    modport source (output valid, token_kind, token_start, token_length, last_of_run,
                    input ready);
    modport sink (input valid, token_kind, token_start, token_length, last_of_run,
                  output ready);
endinterface

// ----- rtl/stt_front.sv -----
// stt_front: lexer state machine, takes one byte beat per cycle unless the queue
// is full, and forms a bundle of up to three tokens; uses stt_pkg and stt_in_if
module stt_front #(
    parameter int POSITION_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    stt_in_if.sink           i_src,
    input  stt_pkg::t_qstat  i_qstat,
    output logic             o_push,
    output stt_pkg::t_bundle o_bundle
);

    localparam int PB = POSITION_BITS;

    stt_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_la0, n_la0;
    logic [1:0]     r_cnt, n_cnt;
    logic [PB-1:0]  r_begin, n_begin, r_pos, n_pos;
    logic           r_point, n_point, r_pb, n_pb, r_dq, n_dq, r_star, n_star;

    stt_pkg::t_bundle b;
    stt_pkg::t_dec    dec;
    logic             fire, do_idle;
    logic [7:0]       c;
    logic [PB-1:0]    b1;

    // bytes left before the position saturates, capped at k
    function automatic logic [PB-1:0] sat_len(input logic [PB-1:0] base, input logic [1:0] k);
        logic [PB-1:0] room;
        room = ~base;
        return (room < PB'(k)) ? room : PB'(k);
    endfunction

    function automatic stt_pkg::t_token mk_tok(input logic [5:0] kind,
                                                input logic [PB-1:0] start,
                                                input logic [PB-1:0] len);
        stt_pkg::t_token t;
        logic [63:0]     ws, wl;
        ws       = 64'(start);
        wl       = 64'(len);
        t.kind   = kind;
        t.start  = ws[31:0];
        t.length = wl[31:0];
        return t;
    endfunction

    assign i_src.ready = !i_qstat.full;
    assign fire        = i_src.valid && i_src.ready;
    assign c           = i_src.ch;
    assign dec         = stt_pkg::decide(r_la0, c);
    assign b1          = r_begin + sat_len(r_begin, 2'd1);

    always_comb begin
        n_mode  = r_mode;
        n_la0   = r_la0;
        n_cnt   = r_cnt;
        n_begin = r_begin;
        n_pos   = r_pos + sat_len(r_pos, 2'd1);
        n_point = r_point;
        n_pb    = r_pb;
        n_dq    = r_dq;
        n_star  = r_star;
        b       = '0;
        do_idle = 1'b0;
        if (i_src.end_of_text) begin
            case (r_mode)
                stt_pkg::M_IDENT: begin
                    b.tok[b.cnt] = mk_tok(stt_pkg::K_IDENT, r_begin, r_pos - r_begin);
                    b.cnt = b.cnt + 2'd1;
                end
                stt_pkg::M_NUMZ, stt_pkg::M_NUM: begin
                    b.tok[b.cnt] = mk_tok(r_point ? stt_pkg::K_FLOAT : stt_pkg::K_INT,
                                          r_begin, r_pos - r_begin);
                    b.cnt = b.cnt + 2'd1;
                end
                stt_pkg::M_LIT: begin
                    b.tok[b.cnt] = mk_tok(r_dq ? stt_pkg::K_STRING : stt_pkg::K_CHAR,
                                          r_begin, r_pos - r_begin);
                    b.cnt = b.cnt + 2'd1;
                end
                stt_pkg::M_PUNCT: begin
                    if (r_cnt == 2'd1) begin
                        b.tok[b.cnt] = mk_tok(stt_pkg::punct_base(r_la0), r_begin,
                                              sat_len(r_begin, 2'd1));
                        b.cnt = b.cnt + 2'd1;
                    end else if (r_cnt == 2'd2) begin
                        case (r_la0)
                            stt_pkg::C_DOT: begin
                                // two lone dots
                                b.tok[b.cnt] = mk_tok(stt_pkg::K_DOT, r_begin,
                                                      sat_len(r_begin, 2'd1));
                                b.cnt = b.cnt + 2'd1;
                                b.tok[b.cnt] = mk_tok(stt_pkg::K_DOT, b1, sat_len(b1, 2'd1));
                                b.cnt = b.cnt + 2'd1;
                            end
                            stt_pkg::C_MINUS: begin
                                b.tok[b.cnt] = mk_tok(stt_pkg::K_ARROW, r_begin,
                                                      sat_len(r_begin, 2'd2));
                                b.cnt = b.cnt + 2'd1;
                            end
                            stt_pkg::C_LT: begin
                                b.tok[b.cnt] = mk_tok(stt_pkg::K_SHL, r_begin,
                                                      sat_len(r_begin, 2'd2));
                                b.cnt = b.cnt + 2'd1;
                            end
                            default: begin
                                b.tok[b.cnt] = mk_tok(stt_pkg::K_SHR, r_begin,
                                                      sat_len(r_begin, 2'd2));
                                b.cnt = b.cnt + 2'd1;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
            b.tok[b.cnt] = mk_tok(stt_pkg::K_EOF, r_pos, '0);
            b.cnt   = b.cnt + 2'd1;
            n_mode  = stt_pkg::M_IDLE;
            n_la0   = '0;
            n_cnt   = '0;
            n_begin = '0;
            n_pos   = '0;
            n_point = 1'b0;
            n_pb    = 1'b0;
            n_dq    = 1'b0;
            n_star  = 1'b0;
        end else begin
            case (r_mode)
                stt_pkg::M_IDLE: do_idle = 1'b1;
                stt_pkg::M_IDENT: begin
                    if (!(stt_pkg::is_head(c) || stt_pkg::is_digit(c))) begin
                        b.tok[b.cnt] = mk_tok(stt_pkg::K_IDENT, r_begin, r_pos - r_begin);
                        b.cnt   = b.cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                stt_pkg::M_NUMZ, stt_pkg::M_NUM: begin
                    if (r_mode == stt_pkg::M_NUMZ && c == stt_pkg::C_X) begin
                        n_mode = stt_pkg::M_NUM;
                    end else if (c == stt_pkg::C_DOT) begin
                        n_point = 1'b1;
                        n_mode  = stt_pkg::M_NUM;
                    end else if (stt_pkg::is_digit(c)) begin
                        n_mode = stt_pkg::M_NUM;
                    end else begin
                        b.tok[b.cnt] = mk_tok(r_point ? stt_pkg::K_FLOAT : stt_pkg::K_INT,
                                              r_begin, r_pos - r_begin);
                        b.cnt   = b.cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                stt_pkg::M_LIT: begin
                    if (c == stt_pkg::C_CR || c == stt_pkg::C_LF ||
                        (!r_pb && c == (r_dq ? stt_pkg::C_DQ : stt_pkg::C_SQ))) begin
                        b.tok[b.cnt] = mk_tok(r_dq ? stt_pkg::K_STRING : stt_pkg::K_CHAR,
                                              r_begin,
                                              r_pos - r_begin + sat_len(r_pos, 2'd1));
                        b.cnt  = b.cnt + 2'd1;
                        n_mode = stt_pkg::M_IDLE;
                        n_pb   = 1'b0;
                    end else begin
                        n_pb = (c == stt_pkg::C_BSL) && !r_pb;
                    end
                end
                stt_pkg::M_LINE: begin
                    if (c == stt_pkg::C_CR || c == stt_pkg::C_LF) n_mode = stt_pkg::M_IDLE;
                end
                stt_pkg::M_BLOCK: begin
                    if (r_star && c == stt_pkg::C_SLASH) n_mode = stt_pkg::M_IDLE;
                    else n_star = (c == stt_pkg::C_STAR);
                end
                stt_pkg::M_PUNCT: begin
                    n_mode = stt_pkg::M_IDLE;
                    n_cnt  = '0;
                    if (r_cnt == 2'd1) begin
                        if (dec.more) begin
                            n_mode = stt_pkg::M_PUNCT;
                            n_cnt  = 2'd2;
                        end else if (dec.line) begin
                            n_mode = stt_pkg::M_LINE;
                        end else if (dec.block) begin
                            n_mode = stt_pkg::M_BLOCK;
                            n_star = 1'b0;
                        end else begin
                            b.tok[b.cnt] = mk_tok(dec.kind, r_begin,
                                                  sat_len(r_begin, dec.two ? 2'd2 : 2'd1));
                            b.cnt   = b.cnt + 2'd1;
                            do_idle = !dec.two;
                        end
                    end else if (r_cnt == 2'd2) begin
                        case (r_la0)
                            stt_pkg::C_DOT: begin
                                if (c == stt_pkg::C_DOT) begin
                                    b.tok[b.cnt] = mk_tok(stt_pkg::K_ELLIP, r_begin,
                                                          sat_len(r_begin, 2'd3));
                                    b.cnt = b.cnt + 2'd1;
                                end else begin
                                    b.tok[b.cnt] = mk_tok(stt_pkg::K_DOT, r_begin,
                                                          sat_len(r_begin, 2'd1));
                                    b.cnt = b.cnt + 2'd1;
                                    if (c == stt_pkg::C_STAR) begin
                                        b.tok[b.cnt] = mk_tok(stt_pkg::K_DOTSTAR, b1,
                                                              sat_len(b1, 2'd2));
                                        b.cnt = b.cnt + 2'd1;
                                    end else begin
                                        b.tok[b.cnt] = mk_tok(stt_pkg::K_DOT, b1,
                                                              sat_len(b1, 2'd1));
                                        b.cnt   = b.cnt + 2'd1;
                                        do_idle = 1'b1;
                                    end
                                end
                            end
                            stt_pkg::C_MINUS: begin
                                b.tok[b.cnt] = mk_tok(
                                    (c == stt_pkg::C_STAR) ? stt_pkg::K_ARROWSTAR
                                                           : stt_pkg::K_ARROW,
                                    r_begin,
                                    sat_len(r_begin, (c == stt_pkg::C_STAR) ? 2'd3 : 2'd2));
                                b.cnt   = b.cnt + 2'd1;
                                do_idle = (c != stt_pkg::C_STAR);
                            end
                            stt_pkg::C_LT: begin
                                b.tok[b.cnt] = mk_tok(
                                    (c == stt_pkg::C_EQ) ? stt_pkg::K_SHLEQ : stt_pkg::K_SHL,
                                    r_begin,
                                    sat_len(r_begin, (c == stt_pkg::C_EQ) ? 2'd3 : 2'd2));
                                b.cnt   = b.cnt + 2'd1;
                                do_idle = (c != stt_pkg::C_EQ);
                            end
                            default: begin
                                b.tok[b.cnt] = mk_tok(
                                    (c == stt_pkg::C_EQ) ? stt_pkg::K_SHREQ : stt_pkg::K_SHR,
                                    r_begin,
                                    sat_len(r_begin, (c == stt_pkg::C_EQ) ? 2'd3 : 2'd2));
                                b.cnt   = b.cnt + 2'd1;
                                do_idle = (c != stt_pkg::C_EQ);
                            end
                        endcase
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            // current byte starts fresh from idle
            if (do_idle) begin
                n_mode = stt_pkg::M_IDLE;
                n_cnt  = '0;
                if (!stt_pkg::is_ws(c)) begin
                    n_begin = r_pos;
                    if (stt_pkg::is_head(c)) begin
                        n_mode = stt_pkg::M_IDENT;
                    end else if (stt_pkg::is_digit(c)) begin
                        n_point = 1'b0;
                        n_mode  = (c == stt_pkg::C_ZERO) ? stt_pkg::M_NUMZ : stt_pkg::M_NUM;
                    end else if (c == stt_pkg::C_SQ || c == stt_pkg::C_DQ) begin
                        n_dq   = (c == stt_pkg::C_DQ);
                        n_pb   = 1'b0;
                        n_mode = stt_pkg::M_LIT;
                    end else if (stt_pkg::needs_look(c)) begin
                        n_la0  = c;
                        n_cnt  = 2'd1;
                        n_mode = stt_pkg::M_PUNCT;
                    end else begin
                        b.tok[b.cnt] = mk_tok(stt_pkg::single_kind(c), r_pos,
                                              sat_len(r_pos, 2'd1));
                        b.cnt = b.cnt + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= stt_pkg::M_IDLE;
            r_la0   <= '0;
            r_cnt   <= '0;
            r_begin <= '0;
            r_pos   <= '0;
            r_point <= 1'b0;
            r_pb    <= 1'b0;
            r_dq    <= 1'b0;
            r_star  <= 1'b0;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_la0   <= n_la0;
            r_cnt   <= n_cnt;
            r_begin <= n_begin;
            r_pos   <= n_pos;
            r_point <= n_point;
            r_pb    <= n_pb;
            r_dq    <= n_dq;
            r_star  <= n_star;
        end
    end

    // the second held byte is implied by the first one, so only the count is kept
    assign o_push   = fire && (b.cnt != 2'd0);
    assign o_bundle = b;

endmodule

// ----- rtl/stt_queue.sv -----
// stt_queue: small fifo of token bundles between lexer and output side
// uses stt_pkg
module stt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stt_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output stt_pkg::t_bundle o_head,
    output stt_pkg::t_qstat  o_qstat
);

    localparam int QAW = $clog2(stt_pkg::QDEPTH);

    stt_pkg::t_bundle r_mem [stt_pkg::QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QAW:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    assign o_head        = r_mem[r_rd];
    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.full  = (r_cnt == (QAW+1)'(stt_pkg::QDEPTH));

endmodule

// ----- rtl/stt_back.sv -----
// stt_back: walks the head bundle and hands out one token beat per cycle
// while the sink is ready; uses stt_pkg and stt_out_if
module stt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stt_pkg::t_bundle i_head,
    input  stt_pkg::t_qstat  i_qstat,
    output logic             o_pop,
    stt_out_if.source        o_tok
);

    logic [1:0] r_idx;
    logic       last, fire;

    assign last  = (r_idx == i_head.cnt - 2'd1);
    assign fire  = o_tok.valid && o_tok.ready;
    assign o_pop = fire && last;

    assign o_tok.valid        = !i_qstat.empty;
    assign o_tok.token_kind   = i_head.tok[r_idx].kind;
    assign o_tok.token_start  = i_head.tok[r_idx].start;
    assign o_tok.token_length = i_head.tok[r_idx].length;
    assign o_tok.last_of_run  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (fire) begin
            r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

// ----- rtl/source_text_tokenizer_unit.sv -----
// Source text tokenizer. One text byte beat is taken per cycle, and the lexer state
// updates in that same cycle; each byte or end marker yields zero to three tokens,
// collected as one bundle into a four-entry queue. The output side sends one token
// beat per cycle while the sink is ready, so the input stalls only when the queue is
// full, which happens when bursts of tokens outrun the consumer. An end-of-text beat
// flushes pending tokens, sends eof and restarts offsets at zero. Positions are
// POSITION_BITS wide and saturate; start and length show the low 32 bits.
module source_text_tokenizer_unit #(
    parameter int POSITION_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_in_if.sink     i_src,
    stt_out_if.source  o_tok
);

    stt_pkg::t_bundle push_bundle, head;
    stt_pkg::t_qstat  qstat;
    logic             push, pop;

    stt_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src    (i_src),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    stt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_qstat  (qstat)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_tok   (o_tok)
    );

endmodule

// ----- tb/source_text_tokenizer_unit_test.sv -----
// testbench for source_text_tokenizer_unit: drives text bytes with random gaps and
// token backpressure, predicts every token and checks them in order
// depends on stt_pkg, stt_in_if/stt_out_if and the tokenizer rtl
`timescale 1ns / 1ps

module source_text_tokenizer_unit_test;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } t_text_beat;

    typedef struct {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic        last;
    } t_expect;

    localparam logic [63:0] POS_LIMIT = 64'hffff_ffff;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stt_in_if  src_if ();
    stt_out_if tok_if ();

    source_text_tokenizer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_tok   (tok_if)
    );

    always #4 i_clk = ~i_clk;

    t_text_beat text_beats[$];
    t_expect    pending_tokens[$];
    t_expect    run_tokens[$];
    int         errors = 0;
    bit         byte_taken = 0;
    int         gap_left = 0;
    int         stall_left = 0;

    // lexer state mirror
    stt_pkg::t_mode lex_mode;
    logic [7:0]     held[2];
    int             held_cnt;
    logic [63:0]    tok_begin;
    logic [63:0]    next_pos;
    bit             point_seen;
    bit             escaped;
    bit             dquote;
    bit             star_seen;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] k);
        if (a > POS_LIMIT - k) return POS_LIMIT;
        return a + k;
    endfunction

    function automatic void clear_lexer();
        lex_mode = stt_pkg::M_IDLE;
        held[0] = '0;
        held[1] = '0;
        held_cnt = 0;
        tok_begin = '0;
        next_pos = '0;
        point_seen = 0;
        escaped = 0;
        dquote = 0;
        star_seen = 0;
    endfunction

    function automatic void put_token(input logic [5:0] kind, input logic [63:0] b,
                                      input logic [63:0] e);
        t_expect t;
        if (run_tokens.size() >= stt_pkg::MAX_TOKENS) return;
        t.kind = kind;
        t.start = b[31:0];
        t.length = 32'(e - b);
        t.last = 1'b0;
        run_tokens.push_back(t);
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == stt_pkg::C_SP || c == stt_pkg::C_TAB || c == stt_pkg::C_FF ||
               c == stt_pkg::C_VT || c == stt_pkg::C_CR || c == stt_pkg::C_LF;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= stt_pkg::C_ZERO && c <= stt_pkg::C_NINE;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return c == stt_pkg::C_USCORE || (c >= stt_pkg::C_UA && c <= stt_pkg::C_UZ) ||
               (c >= stt_pkg::C_LA && c <= stt_pkg::C_LZ);
    endfunction

    // 0 needs more bytes, 1 token, 2 line comment, 3 block comment
    function automatic int classify_punct(input logic [7:0] s[3], input int n, input bit fin,
                                          output int len, output logic [5:0] kind);
        int a, b;
        logic [5:0] base;
        len = 1;
        kind = stt_pkg::K_UNKNOWN;
        a = (n > 1) ? int'(s[1]) : (fin ? -1 : -2);
        b = (n > 2) ? int'(s[2]) : (fin ? -1 : -2);
        if (a == -2) return 0;
        case (s[0])
            stt_pkg::C_BANG:  base = stt_pkg::K_NOT;
            stt_pkg::C_HASH:  base = stt_pkg::K_HASH;
            stt_pkg::C_COLON: base = stt_pkg::K_COLON;
            stt_pkg::C_DOT:   base = stt_pkg::K_DOT;
            stt_pkg::C_PLUS:  base = stt_pkg::K_PLUS;
            stt_pkg::C_MINUS: base = stt_pkg::K_MINUS;
            stt_pkg::C_STAR:  base = stt_pkg::K_STAR;
            stt_pkg::C_SLASH: base = stt_pkg::K_SLASH;
            stt_pkg::C_PCT:   base = stt_pkg::K_PCT;
            stt_pkg::C_CARET: base = stt_pkg::K_CARET;
            stt_pkg::C_AMP:   base = stt_pkg::K_AMP;
            stt_pkg::C_BAR:   base = stt_pkg::K_BAR;
            stt_pkg::C_EQ:    base = stt_pkg::K_ASSIGN;
            stt_pkg::C_LT:    base = stt_pkg::K_LT;
            stt_pkg::C_GT:    base = stt_pkg::K_GT;
            default:          base = stt_pkg::K_UNKNOWN;
        endcase
        kind = base;
        case (s[0])
            stt_pkg::C_BANG, stt_pkg::C_STAR, stt_pkg::C_PCT, stt_pkg::C_CARET, stt_pkg::C_EQ:
                if (a == stt_pkg::C_EQ) begin kind = base + 6'd1; len = 2; end
            stt_pkg::C_HASH, stt_pkg::C_COLON:
                if (a == s[0]) begin kind = base + 6'd1; len = 2; end
            stt_pkg::C_PLUS, stt_pkg::C_AMP, stt_pkg::C_BAR: begin
                if (a == s[0]) begin kind = base + 6'd1; len = 2; end
                else if (a == stt_pkg::C_EQ) begin kind = base + 6'd2; len = 2; end
            end
            stt_pkg::C_DOT: begin
                if (a == stt_pkg::C_DOT) begin
                    if (b == -2) return 0;
                    if (b == stt_pkg::C_DOT) begin kind = stt_pkg::K_ELLIP; len = 3; end
                end else if (a == stt_pkg::C_STAR) begin
                    kind = stt_pkg::K_DOTSTAR; len = 2;
                end
            end
            stt_pkg::C_MINUS: begin
                if (a == stt_pkg::C_MINUS) begin kind = stt_pkg::K_DEC; len = 2; end
                else if (a == stt_pkg::C_EQ) begin kind = stt_pkg::K_SUBEQ; len = 2; end
                else if (a == stt_pkg::C_GT) begin
                    if (b == -2) return 0;
                    if (b == stt_pkg::C_STAR) begin kind = stt_pkg::K_ARROWSTAR; len = 3; end
                    else begin kind = stt_pkg::K_ARROW; len = 2; end
                end
            end
            stt_pkg::C_SLASH: begin
                if (a == stt_pkg::C_SLASH) begin len = 2; return 2; end
                if (a == stt_pkg::C_STAR) begin len = 2; return 3; end
                if (a == stt_pkg::C_EQ) begin kind = stt_pkg::K_DIVEQ; len = 2; end
            end
            stt_pkg::C_LT, stt_pkg::C_GT: begin
                if (a == s[0]) begin
                    if (b == -2) return 0;
                    if (b == stt_pkg::C_EQ) begin kind = base + 6'd2; len = 3; end
                    else begin kind = base + 6'd1; len = 2; end
                end else if (a == stt_pkg::C_EQ) begin
                    kind = base + 6'd3; len = 2;
                end
            end
            default: ;
        endcase
        return 1;
    endfunction

    function automatic void settle_punct(input logic [7:0] s[3], input int n, input int r,
                                         input int len, input logic [5:0] kind);
        logic [63:0] b0;
        b0 = tok_begin;
        lex_mode = stt_pkg::M_IDLE;
        held_cnt = 0;
        if (r == 1) put_token(kind, b0, sat_add(b0, 64'(len)));
        else if (r == 2) lex_mode = stt_pkg::M_LINE;
        else begin
            lex_mode = stt_pkg::M_BLOCK;
            star_seen = 0;
        end
        for (int i = len; i < n; i++) lex_byte(s[i], sat_add(b0, 64'(i)));
    endfunction

    function automatic void lex_byte(input logic [7:0] c, input logic [63:0] pos);
        logic [7:0] s[3];
        int cnt, r, len;
        logic [5:0] kind;
        case (lex_mode)
            stt_pkg::M_IDLE: begin
                if (is_space(c)) return;
                tok_begin = pos;
                if (is_alpha(c)) lex_mode = stt_pkg::M_IDENT;
                else if (is_num(c)) begin
                    point_seen = 0;
                    lex_mode = (c == stt_pkg::C_ZERO) ? stt_pkg::M_NUMZ : stt_pkg::M_NUM;
                end else if (c == stt_pkg::C_SQ || c == stt_pkg::C_DQ) begin
                    dquote = (c == stt_pkg::C_DQ);
                    escaped = 0;
                    lex_mode = stt_pkg::M_LIT;
                end else if (c inside {stt_pkg::C_BANG, stt_pkg::C_HASH, stt_pkg::C_COLON,
                                       stt_pkg::C_DOT, stt_pkg::C_PLUS, stt_pkg::C_MINUS,
                                       stt_pkg::C_STAR, stt_pkg::C_SLASH, stt_pkg::C_PCT,
                                       stt_pkg::C_CARET, stt_pkg::C_AMP, stt_pkg::C_BAR,
                                       stt_pkg::C_EQ, stt_pkg::C_LT, stt_pkg::C_GT}) begin
                    held[0] = c;
                    held_cnt = 1;
                    lex_mode = stt_pkg::M_PUNCT;
                end else begin
                    case (c)
                        stt_pkg::C_LBRACE: kind = stt_pkg::K_LBRACE;
                        stt_pkg::C_RBRACE: kind = stt_pkg::K_RBRACE;
                        stt_pkg::C_LBRK:   kind = stt_pkg::K_LBRK;
                        stt_pkg::C_RBRK:   kind = stt_pkg::K_RBRK;
                        stt_pkg::C_LPAR:   kind = stt_pkg::K_LPAR;
                        stt_pkg::C_RPAR:   kind = stt_pkg::K_RPAR;
                        stt_pkg::C_SEMI:   kind = stt_pkg::K_SEMI;
                        stt_pkg::C_QUEST:  kind = stt_pkg::K_QUEST;
                        stt_pkg::C_TILDE:  kind = stt_pkg::K_TILDE;
                        stt_pkg::C_COMMA:  kind = stt_pkg::K_COMMA;
                        default:           kind = stt_pkg::K_UNKNOWN;
                    endcase
                    put_token(kind, pos, sat_add(pos, 64'd1));
                end
            end
            stt_pkg::M_IDENT: begin
                if (is_alpha(c) || is_num(c)) return;
                put_token(stt_pkg::K_IDENT, tok_begin, pos);
                lex_mode = stt_pkg::M_IDLE;
                lex_byte(c, pos);
            end
            stt_pkg::M_NUMZ: begin
                lex_mode = stt_pkg::M_NUM;
                if (c != stt_pkg::C_X) lex_byte(c, pos);
            end
            stt_pkg::M_NUM: begin
                if (c == stt_pkg::C_DOT) point_seen = 1;
                else if (!is_num(c)) begin
                    put_token(point_seen ? stt_pkg::K_FLOAT : stt_pkg::K_INT, tok_begin, pos);
                    lex_mode = stt_pkg::M_IDLE;
                    lex_byte(c, pos);
                end
            end
            stt_pkg::M_LIT: begin
                if (c == stt_pkg::C_CR || c == stt_pkg::C_LF ||
                    (!escaped && c == (dquote ? stt_pkg::C_DQ : stt_pkg::C_SQ))) begin
                    put_token(dquote ? stt_pkg::K_STRING : stt_pkg::K_CHAR, tok_begin,
                              sat_add(pos, 64'd1));
                    lex_mode = stt_pkg::M_IDLE;
                    escaped = 0;
                end else begin
                    escaped = (c == stt_pkg::C_BSL) && !escaped;
                end
            end
            stt_pkg::M_LINE:
                if (c == stt_pkg::C_CR || c == stt_pkg::C_LF) lex_mode = stt_pkg::M_IDLE;
            stt_pkg::M_BLOCK: begin
                if (star_seen && c == stt_pkg::C_SLASH) lex_mode = stt_pkg::M_IDLE;
                else star_seen = (c == stt_pkg::C_STAR);
            end
            stt_pkg::M_PUNCT: begin
                cnt = (held_cnt > 2) ? 2 : held_cnt;
                if (cnt == 0) begin
                    lex_mode = stt_pkg::M_IDLE;
                    lex_byte(c, pos);
                    return;
                end
                s[0] = held[0];
                s[1] = held[1];
                s[2] = 8'h00;
                s[cnt] = c;
                r = classify_punct(s, cnt + 1, 0, len, kind);
                if (r == 0) begin
                    if (cnt < 2) begin
                        held[cnt] = c;
                        held_cnt = cnt + 1;
                    end
                end else begin
                    settle_punct(s, cnt + 1, r, len, kind);
                end
            end
            default: begin
                lex_mode = stt_pkg::M_IDLE;
                lex_byte(c, pos);
            end
        endcase
    endfunction

    function automatic void flush_pending();
        logic [7:0] s[3];
        int cnt, r, len;
        logic [5:0] kind;
        for (int guard = 0; guard < 4 && lex_mode != stt_pkg::M_IDLE; guard++) begin
            case (lex_mode)
                stt_pkg::M_IDENT: put_token(stt_pkg::K_IDENT, tok_begin, next_pos);
                stt_pkg::M_NUMZ, stt_pkg::M_NUM:
                    put_token(point_seen ? stt_pkg::K_FLOAT : stt_pkg::K_INT, tok_begin,
                              next_pos);
                stt_pkg::M_LIT:
                    put_token(dquote ? stt_pkg::K_STRING : stt_pkg::K_CHAR, tok_begin,
                              next_pos);
                stt_pkg::M_PUNCT: begin
                    cnt = (held_cnt > 2) ? 2 : held_cnt;
                    if (cnt != 0) begin
                        s[0] = held[0];
                        s[1] = held[1];
                        s[2] = 8'h00;
                        r = classify_punct(s, cnt, 1, len, kind);
                        if (r == 0) begin
                            r = 1;
                            len = 1;
                            kind = stt_pkg::K_UNKNOWN;
                        end
                        settle_punct(s, cnt, r, len, kind);
                        continue;
                    end
                end
                default: ;
            endcase
            lex_mode = stt_pkg::M_IDLE;
        end
        lex_mode = stt_pkg::M_IDLE;
    endfunction

    function automatic void predict_tokens(input logic [7:0] c, input logic eot);
        logic [63:0] pos;
        run_tokens.delete();
        if (eot) begin
            flush_pending();
            put_token(stt_pkg::K_EOF, next_pos, next_pos);
            clear_lexer();
        end else begin
            pos = next_pos;
            next_pos = sat_add(pos, 64'd1);
            lex_byte(c, pos);
        end
        if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1'b1;
        foreach (run_tokens[i]) pending_tokens.push_back(run_tokens[i]);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic push_byte(input logic [7:0] c);
        t_text_beat t;
        t.ch = c;
        t.eot = 1'b0;
        text_beats.push_back(t);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_end();
        t_text_beat t;
        t.ch = 8'($urandom);
        t.eot = 1'b1;
        text_beats.push_back(t);
    endtask

    function automatic logic [7:0] rand_alpha();
        logic [7:0] pick;
        pick = 8'($urandom_range(0, 52));
        if (pick == 8'd52) return stt_pkg::C_USCORE;
        return (pick < 8'd26) ? stt_pkg::C_UA + pick : stt_pkg::C_LA + pick - 8'd26;
    endfunction

    task automatic push_fragment();
        string puncts[$] = '{"!", "!=", "#", "##", ":", "::", ".", "...", ".*", "..", "+",
            "++", "+=", "-", "--", "-=", "->", "->*", "*", "*=", "/", "/=", "%", "%=", "^",
            "^=", "&", "&&", "&=", "|", "||", "|=", "=", "==", "<", "<<", "<<=", "<=", ">",
            ">>", ">>=", ">=", "{", "}", "[", "]", "(", ")", ";", "?", "~", ",", "<<<"};
        logic [7:0] lit_set[8] = '{stt_pkg::C_SQ, stt_pkg::C_DQ, stt_pkg::C_BSL,
                                   stt_pkg::C_BSL, stt_pkg::C_LA, stt_pkg::C_SP,
                                   8'h00, 8'hfe};
        logic [7:0] ws_set[6] = '{stt_pkg::C_SP, stt_pkg::C_TAB, stt_pkg::C_FF,
                                  stt_pkg::C_VT, stt_pkg::C_CR, stt_pkg::C_LF};
        int n;
        case ($urandom_range(0, 11))
            0: begin
                push_byte(rand_alpha());
                n = $urandom_range(0, 4);
                repeat (n) push_byte($urandom_range(0, 3) == 0
                                     ? 8'(stt_pkg::C_ZERO + $urandom_range(0, 9))
                                     : rand_alpha());
            end
            1: begin
                if ($urandom_range(0, 2) == 0) push_str("0x");
                else push_byte(8'(stt_pkg::C_ZERO + $urandom_range(0, 9)));
                n = $urandom_range(0, 4);
                repeat (n) push_byte($urandom_range(0, 4) == 0
                                     ? stt_pkg::C_DOT
                                     : 8'(stt_pkg::C_ZERO + $urandom_range(0, 9)));
            end
            2: begin
                push_byte($urandom_range(0, 1) ? stt_pkg::C_DQ : stt_pkg::C_SQ);
                n = $urandom_range(0, 5);
                repeat (n) push_byte(lit_set[$urandom_range(0, 7)]);
                case ($urandom_range(0, 3))
                    0: push_byte(stt_pkg::C_LF);
                    1: push_byte(stt_pkg::C_CR);
                    default: push_byte($urandom_range(0, 1) ? stt_pkg::C_DQ : stt_pkg::C_SQ);
                endcase
            end
            3: begin
                push_str("//");
                n = $urandom_range(0, 3);
                repeat (n) push_byte($urandom_range(0, 1) ? stt_pkg::C_STAR : stt_pkg::C_LA);
                push_byte($urandom_range(0, 1) ? stt_pkg::C_CR : stt_pkg::C_LF);
            end
            4: begin
                push_str("/*");
                n = $urandom_range(0, 4);
                repeat (n) push_byte($urandom_range(0, 2) == 0 ? stt_pkg::C_SLASH
                                     : ($urandom_range(0, 1) ? stt_pkg::C_STAR
                                                             : stt_pkg::C_LA));
                push_str("*/");
            end
            5, 6, 7: push_str(puncts[$urandom_range(0, puncts.size() - 1)]);
            8: push_byte(ws_set[$urandom_range(0, 5)]);
            9: push_byte(8'($urandom_range(0, 255)));
            default: push_end();
        endcase
    endtask

    // monitor: predict on each accepted byte, check each accepted token
    always @(posedge i_clk) begin
        byte_taken = 0;
        if (i_rst_n) begin
            if (src_if.valid && src_if.ready) begin
                predict_tokens(src_if.ch, src_if.end_of_text);
                byte_taken = 1;
            end
            if (tok_if.valid && tok_if.ready) begin
                if (pending_tokens.size() == 0) begin
                    report("unexpected token kind", 32'(tok_if.token_kind), 32'd0);
                end else begin
                    t_expect want;
                    want = pending_tokens.pop_front();
                    if (tok_if.token_kind !== want.kind)
                        report("kind", 32'(tok_if.token_kind), 32'(want.kind));
                    if (tok_if.token_start !== want.start)
                        report("start", tok_if.token_start, want.start);
                    if (tok_if.token_length !== want.length)
                        report("length", tok_if.token_length, want.length);
                    if (tok_if.last_of_run !== want.last)
                        report("last", 32'(tok_if.last_of_run), 32'(want.last));
                end
            end
        end
    end

    // driver: holds a beat until taken, idles in bursts while the queue is long
    always @(negedge i_clk) begin
        if (i_rst_n && !(src_if.valid && !byte_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                src_if.valid <= 1'b0;
            end else if (text_beats.size() > 60 && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 15);
                src_if.valid <= 1'b0;
            end else if (text_beats.size() > 0) begin
                t_text_beat t;
                t = text_beats.pop_front();
                src_if.valid <= 1'b1;
                src_if.ch <= t.ch;
                src_if.end_of_text <= t.eot;
            end else begin
                src_if.valid <= 1'b0;
            end
        end
    end

    // token sink backpressure
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                tok_if.ready <= 1'b0;
            end else if (text_beats.size() > 60 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                tok_if.ready <= 1'b0;
            end else begin
                tok_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        src_if.valid = 1'b0;
        src_if.ch = 8'h00;
        src_if.end_of_text = 1'b0;
        tok_if.ready = 1'b0;
        clear_lexer();

        // directed: identifier, hex float, escaped char, odd bytes, comments, shifts
        push_str("_Zz9 0x.5");
        push_str("'\\''");
        push_byte(8'h00);
        push_byte(8'hff);
        push_str("//");
        push_byte(stt_pkg::C_LF);
        push_str("/**/");
        push_str(">>=");
        push_end();
        // pending punctuator, open literal and open comment flushed at end
        push_str("->");
        push_end();
        push_str("\"a");
        push_end();
        push_str("/*");
        push_end();

        while (text_beats.size() < 330) push_fragment();
        push_end();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (text_beats.size() == 0);
        @(posedge i_clk);
        while (src_if.valid) @(posedge i_clk);
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- source_text_tokenizer_unit.f -----
rtl/stt_pkg.sv
rtl/stt_if.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/stt_back.sv
rtl/source_text_tokenizer_unit.sv
tb/source_text_tokenizer_unit_test.sv
